// ===== rtl/bmhq_pkg.sv =====
`default_nettype none
package bmhq_pkg;

  localparam int DEPTH  = 64;
  localparam int KEY_W  = 32;
  localparam int TAG_W  = 8;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = IDX_W + 1;
  localparam int CAP_W  = 7;
  localparam int REQ_W  = 2;
  localparam int STAT_W = 2;

  localparam int ENTRY_W    = KEY_W + TAG_W;
  localparam int IN_DATA_W  = ((ENTRY_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((ENTRY_W + CNT_W + 7) / 8) * 8;
  localparam int OUT_USER_W = 1 + STAT_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_UP_CMP,
    S_RM,
    S_DN,
    S_DN_CMP,
    S_FIN
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/bmhq_ram.sv =====
`default_nettype none
module bmhq_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_a_addr,
  output logic      [WIDTH-1:0]  rd_a_data,
  input  wire logic [ADDR_W-1:0] rd_b_addr,
  output logic      [WIDTH-1:0]  rd_b_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule
`default_nettype wire

// ===== rtl/binary_min_heap_queue.sv =====
`default_nettype none
// Channel   Direction  Contents
// in_       slave      tuser: req_type; tdata: entry_key, entry_tag
// out_      master     tuser: out_valid, status; tdata: out_key, out_tag, occupancy
// cfg_      write      capacity_limit
//
// One request is taken at a time; in_tready is high only while the sequencer is idle.
// Insert sifts up one level per S_UP_CMP state, comparing with the parent from read port A.
// Remove first reads the root and the last entry; each sift-down level then reads both
// children from the dual read port RAM and compares them in the next cycle.
// Full, empty, clear and unused requests go straight to S_FIN. A stalled result is held in
// the output register while the next request is worked on; completion waits for it.
// Reset clears the entry count and restores the limit; the entry RAM is not cleared.
module binary_min_heap_queue
  import bmhq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // entry_key, entry_tag
  input  wire logic [REQ_W-1:0]      in_tuser,   // req_type
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // out_key, out_tag, occupancy
  output logic [OUT_USER_W-1:0]      out_tuser,  // out_valid, status
  input  wire logic                  cfg_wr_en,
  input  wire logic [CAP_W-1:0]      cfg_wr_data
);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CAP_W-1:0]   cap_r;
  logic [IDX_W-1:0]   pos_r, pos_nxt;
  entry_t             mov_r, mov_nxt;
  entry_t             res_ent_r, res_ent_nxt;
  logic               res_valid_r, res_valid_nxt;
  status_t            res_status_r, res_status_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;
  entry_t             out_ent_r;
  logic               out_flag_r;
  status_t            out_stat_r;
  logic [CNT_W-1:0]   out_occ_r;

  logic               ram_wr_en;
  logic [IDX_W-1:0]   ram_wr_addr;
  entry_t             ram_wr_data;
  logic [IDX_W-1:0]   rd_a_addr, rd_b_addr;
  logic [ENTRY_W-1:0] rd_a_raw, rd_b_raw;
  entry_t             rd_a, rd_b;

  logic               accept;
  logic               full;
  logic               fin_ok;
  logic [IDX_W-1:0]   pos_m1, parent, par_m1, gparent;
  logic [CNT_W-1:0]   left, right, last;
  logic               pick_right;
  entry_t             pick;
  logic [IDX_W-1:0]   pick_idx;
  entry_t             in_ent;

  bmhq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk       (clk),
    .wr_en     (ram_wr_en),
    .wr_addr   (ram_wr_addr),
    .wr_data   (ram_wr_data),
    .rd_a_addr (rd_a_addr),
    .rd_a_data (rd_a_raw),
    .rd_b_addr (rd_b_addr),
    .rd_b_data (rd_b_raw)
  );

  assign rd_a = entry_t'(rd_a_raw);
  assign rd_b = entry_t'(rd_b_raw);

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign fin_ok    = !out_tvalid_r || out_tready;
  assign in_ent    = entry_t'({in_tdata[KEY_W-1:0], in_tdata[ENTRY_W-1:KEY_W]});

  // The effective limit is the smaller of the register and the RAM depth.
  assign full = (32'(count_r) >= 32'(cap_r)) || (32'(count_r) >= DEPTH);

  assign pos_m1  = pos_r - IDX_W'(1);
  assign parent  = {1'b0, pos_m1[IDX_W-1:1]};
  assign par_m1  = parent - IDX_W'(1);
  assign gparent = {1'b0, par_m1[IDX_W-1:1]};
  assign left    = {pos_r, 1'b1};
  assign right   = left + CNT_W'(1);
  assign last    = count_r - CNT_W'(1);

  // On equal child keys the left child wins.
  assign pick_right = (right < count_r) && (rd_b.key < rd_a.key);
  assign pick       = pick_right ? rd_b : rd_a;
  assign pick_idx   = pick_right ? right[IDX_W-1:0] : left[IDX_W-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_tuser)
            REQ_INSERT: state_nxt = full ? S_FIN : S_UP;
            REQ_REMOVE: state_nxt = (count_r == '0) ? S_FIN : S_RM;
            default:    state_nxt = S_FIN;
          endcase
        end
      end
      S_UP: begin
        state_nxt = (pos_r == '0) ? S_FIN : S_UP_CMP;
      end
      S_UP_CMP: begin
        if (mov_r.key < rd_a.key) begin
          state_nxt = (parent == '0) ? S_UP : S_UP_CMP;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_RM: begin
        state_nxt = S_DN;
      end
      S_DN: begin
        state_nxt = (left >= count_r) ? S_FIN : S_DN_CMP;
      end
      S_DN_CMP: begin
        state_nxt = (mov_r.key > pick.key) ? S_DN : S_FIN;
      end
      S_FIN: begin
        if (fin_ok) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // The moving entry is kept in mov_r and the hole it will fill in pos_r, so each
  // level costs one write instead of a swap.
  always_comb begin
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    mov_nxt        = mov_r;
    res_ent_nxt    = res_ent_r;
    res_valid_nxt  = res_valid_r;
    res_status_nxt = res_status_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = pos_r;
    ram_wr_data    = mov_r;
    rd_a_addr      = parent;
    rd_b_addr      = right[IDX_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_ent_nxt    = '0;
          res_valid_nxt  = 1'b0;
          res_status_nxt = STAT_OK;
          case (in_tuser)
            REQ_INSERT: begin
              if (full) begin
                res_status_nxt = STAT_FULL;
              end else begin
                mov_nxt   = in_ent;
                pos_nxt   = count_r[IDX_W-1:0];
                count_nxt = count_r + CNT_W'(1);
              end
            end
            REQ_REMOVE: begin
              if (count_r == '0) begin
                res_status_nxt = STAT_EMPTY;
              end else begin
                rd_a_addr = '0;
                rd_b_addr = last[IDX_W-1:0];
              end
            end
            REQ_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_UP: begin
        if (pos_r == '0) begin
          ram_wr_en = 1'b1;
        end
      end
      S_UP_CMP: begin
        ram_wr_en = 1'b1;
        if (mov_r.key < rd_a.key) begin
          ram_wr_data = rd_a;
          pos_nxt     = parent;
          rd_a_addr   = gparent;
        end
      end
      S_RM: begin
        res_valid_nxt = 1'b1;
        res_ent_nxt   = rd_a;
        mov_nxt       = rd_b;
        count_nxt     = last;
        pos_nxt       = '0;
      end
      S_DN: begin
        if (left >= count_r) begin
          ram_wr_en = 1'b1;
        end else begin
          rd_a_addr = left[IDX_W-1:0];
          rd_b_addr = right[IDX_W-1:0];
        end
      end
      S_DN_CMP: begin
        ram_wr_en = 1'b1;
        if (mov_r.key > pick.key) begin
          ram_wr_data = pick;
          pos_nxt     = pick_idx;
        end
      end
      S_FIN: begin
        if (fin_ok) begin
          out_tvalid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      cap_r        <= CAP_RESET;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    mov_r        <= mov_nxt;
    res_ent_r    <= res_ent_nxt;
    res_valid_r  <= res_valid_nxt;
    res_status_r <= res_status_nxt;
    if (state_r == S_FIN && fin_ok) begin
      out_ent_r  <= res_ent_r;
      out_flag_r <= res_valid_r;
      out_stat_r <= res_status_r;
      out_occ_r  <= count_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_DATA_W'({out_occ_r, out_ent_r.tag, out_ent_r.key});
  assign out_tuser  = {out_stat_r, out_flag_r};

endmodule
`default_nettype wire

// ===== tb/bmhq_checker.sv =====
module bmhq_checker
  import bmhq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // entry_key, entry_tag
  input  wire logic [REQ_W-1:0]      in_tuser,   // req_type
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic [OUT_DATA_W-1:0] out_tdata,  // out_key, out_tag, occupancy
  input  wire logic [OUT_USER_W-1:0] out_tuser,  // out_valid, status
  input  wire logic                  cfg_wr_en,
  input  wire logic [CAP_W-1:0]      cfg_wr_data,
  output int                         fail_count,
  output int                         open_count
);

  typedef struct packed {
    logic             found;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    status_t          status;
    logic [CNT_W-1:0] occupancy;
  } heap_result_t;

  logic [KEY_W-1:0] shadow_keys [DEPTH];
  logic [TAG_W-1:0] shadow_tags [DEPTH];
  int               shadow_count;
  logic [CAP_W-1:0] shadow_limit;
  heap_result_t     due_results [$];
  int               mismatches = 0;

  function automatic void swap_slots(input int a, input int b);
    logic [KEY_W-1:0] k;
    logic [TAG_W-1:0] t;
    k = shadow_keys[a];
    t = shadow_tags[a];
    shadow_keys[a] = shadow_keys[b];
    shadow_tags[a] = shadow_tags[b];
    shadow_keys[b] = k;
    shadow_tags[b] = t;
  endfunction

  function automatic heap_result_t serve_request(input logic [REQ_W-1:0] req,
                                                 input logic [KEY_W-1:0] key,
                                                 input logic [TAG_W-1:0] tag);
    heap_result_t res;
    int           lim;
    int           pos;
    int           parent;
    int           left;
    int           pick;
    bit           done;
    res = '0;
    res.status = STAT_OK;
    lim = (shadow_limit < DEPTH) ? int'(shadow_limit) : DEPTH;
    case (req)
      REQ_INSERT: begin
        if (shadow_count >= lim) begin
          res.status = STAT_FULL;
        end else begin
          pos = shadow_count;
          shadow_keys[pos] = key;
          shadow_tags[pos] = tag;
          shadow_count++;
          done = 1'b0;
          while (pos != 0 && !done) begin
            parent = (pos - 1) / 2;
            if (shadow_keys[pos] < shadow_keys[parent]) begin
              swap_slots(pos, parent);
              pos = parent;
            end else begin
              done = 1'b1;
            end
          end
        end
      end
      REQ_REMOVE: begin
        if (shadow_count == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          res.found = 1'b1;
          res.key = shadow_keys[0];
          res.tag = shadow_tags[0];
          shadow_count--;
          shadow_keys[0] = shadow_keys[shadow_count];
          shadow_tags[0] = shadow_tags[shadow_count];
          pos = 0;
          done = 1'b0;
          while (!done) begin
            left = pos * 2 + 1;
            if (left >= shadow_count) begin
              done = 1'b1;
            end else begin
              // On equal child keys the left child wins.
              pick = left;
              if (left + 1 < shadow_count && shadow_keys[left + 1] < shadow_keys[left]) begin
                pick = left + 1;
              end
              if (shadow_keys[pos] > shadow_keys[pick]) begin
                swap_slots(pos, pick);
                pos = pick;
              end else begin
                done = 1'b1;
              end
            end
          end
        end
      end
      REQ_CLEAR: begin
        shadow_count = 0;
      end
      default: begin
      end
    endcase
    res.occupancy = CNT_W'(shadow_count);
    return res;
  endfunction

  function automatic void compare_field(input string name, input logic [KEY_W-1:0] want,
                                        input logic [KEY_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : track
    heap_result_t got;
    heap_result_t want;
    if (!rst_n) begin
      shadow_count = 0;
      shadow_limit = CAP_RESET;
      due_results.delete();
    end else begin
      // A result leaving at this edge always belongs to an earlier transaction.
      if (out_tvalid && out_tready) begin
        got.found     = out_tuser[0];
        got.status    = status_t'(out_tuser[1 +: STAT_W]);
        got.key       = out_tdata[KEY_W-1:0];
        got.tag       = out_tdata[KEY_W +: TAG_W];
        got.occupancy = out_tdata[ENTRY_W +: CNT_W];
        if (due_results.size() == 0) begin
          $error("result transaction with no request outstanding");
          mismatches++;
        end else begin
          want = due_results.pop_front();
          compare_field("out_valid", KEY_W'(want.found), KEY_W'(got.found));
          compare_field("out_key", want.key, got.key);
          compare_field("out_tag", KEY_W'(want.tag), KEY_W'(got.tag));
          compare_field("status", KEY_W'(want.status), KEY_W'(out_tuser[1 +: STAT_W]));
          compare_field("occupancy", KEY_W'(want.occupancy), KEY_W'(got.occupancy));
        end
      end
      if (cfg_wr_en) begin
        shadow_limit = cfg_wr_data;
      end
      if (in_tvalid && in_tready) begin
        due_results.push_back(serve_request(in_tuser, in_tdata[KEY_W-1:0],
                                            in_tdata[KEY_W +: TAG_W]));
      end
    end
    fail_count <= mismatches;
    open_count <= due_results.size();
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import bmhq_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 24;
  localparam int LONG_HOLD      = 300;
  localparam int NUM_PHASES     = 7;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // entry_key, entry_tag
  logic [REQ_W-1:0]      in_tuser = '0;   // req_type
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // out_key, out_tag, occupancy
  logic [OUT_USER_W-1:0] out_tuser;       // out_valid, status
  logic                  cfg_wr_en = 1'b0;
  logic [CAP_W-1:0]      cfg_wr_data = '0;

  int fail_count;
  int open_count;
  int hold_asked = 0;
  int quiet_cycles = 0;
  bit steady = 1'b0;

  always #5 clk = ~clk;

  binary_min_heap_queue DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  bmhq_checker watch (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .open_count  (open_count)
  );

  // Mostly short pauses, now and then a long one.
  function automatic int idle_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      return $urandom_range(1, 3);
    end else if (roll < 95) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random back-pressure, plus a long hold whenever one is asked for.
  initial begin : sink
    int stall_left;
    int hold_served;
    stall_left = 0;
    hold_served = 0;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_served) begin
        hold_served = hold_served + 1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (steady || !rst_n) begin
        out_tready <= 1'b1;
      end else if ($urandom_range(0, 99) < 70) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        stall_left = idle_length() - 1;
      end
    end
  end

  task automatic offer(input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] key,
                       input logic [TAG_W-1:0] tag);
    int gap;
    gap = (steady || $urandom_range(0, 1) == 0) ? 0 : idle_length();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'({tag, key});
    in_tuser  <= req;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop offering and wait until every outstanding result has been taken.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(input logic [CAP_W-1:0] value);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic offer_random(input int insert_pct);
    int               roll;
    logic [REQ_W-1:0] req;
    logic [KEY_W-1:0] key;
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      req = REQ_CLEAR;
    end else if (roll < 4) begin
      req = REQ_UNUSED;
    end else if ($urandom_range(0, 99) < insert_pct) begin
      req = REQ_INSERT;
    end else begin
      req = REQ_REMOVE;
    end
    // A narrow key range gives plenty of equal keys, so tie handling is exercised.
    roll = $urandom_range(0, 99);
    if (roll < 25) begin
      key = $urandom_range(0, 7);
    end else if (roll < 30) begin
      key = '0;
    end else if (roll < 35) begin
      key = '1;
    end else begin
      key = $urandom;
    end
    offer(req, key, TAG_W'($urandom_range(0, 255)));
  endtask

  initial begin : stimulus
    logic [CAP_W-1:0] phase_limit [NUM_PHASES];
    int               phase_items [NUM_PHASES];
    phase_limit = '{7'd127, 7'd64, 7'd1, 7'd2, 7'd0, 7'd64, 7'd64};
    phase_items = '{140, 80, 40, 40, 20, 90, 90};
    phase_limit[5] = CAP_W'($urandom_range(3, 63));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer(REQ_REMOVE, '0, '0);
    offer(REQ_UNUSED, '1, '1);
    offer(REQ_INSERT, '1, 8'hFF);
    offer(REQ_INSERT, '0, 8'h00);
    offer(REQ_INSERT, 32'd5, 8'h11);
    offer(REQ_INSERT, 32'd5, 8'h22);
    offer(REQ_INSERT, 32'd5, 8'h33);
    offer(REQ_INSERT, 32'h8000_0000, 8'hAA);
    offer(REQ_INSERT, 32'h7FFF_FFFF, 8'h55);
    offer(REQ_UNUSED, 32'h1234_5678, 8'h5A);
    repeat (5) offer(REQ_REMOVE, '0, '0);
    offer(REQ_CLEAR, 32'hA5A5_A5A5, 8'hC3);
    offer(REQ_REMOVE, '0, '0);

    set_limit(7'd2);
    offer(REQ_INSERT, 32'd9, 8'h01);
    offer(REQ_INSERT, 32'd3, 8'h02);
    offer(REQ_INSERT, 32'd7, 8'h03);

    // The limit now sits below the number of entries already held.
    set_limit(7'd1);
    offer(REQ_INSERT, 32'd1, 8'h04);
    offer(REQ_REMOVE, '0, '0);
    offer(REQ_INSERT, 32'd2, 8'h05);
    offer(REQ_REMOVE, '0, '0);
    offer(REQ_INSERT, 32'd4, 8'h06);
    offer(REQ_CLEAR, '0, '0);

    set_limit(7'd0);
    offer(REQ_INSERT, 32'd6, 8'h07);

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_limit(phase_limit[p]);
      if (p == 0) begin
        hold_asked <= hold_asked + 1;
      end
      if (p == NUM_PHASES - 1) begin
        steady <= 1'b1;
      end
      for (int i = 0; i < phase_items[p]; i++) begin
        offer_random((i < phase_items[p] * 7 / 10) ? 90 : 25);
      end
    end

    settle();
    if (fail_count == 0 && open_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bmhq_pkg.sv
rtl/bmhq_ram.sv
rtl/binary_min_heap_queue.sv
tb/bmhq_checker.sv
tb/tb_top.sv
